/* rtl/pwl_pkg.sv */
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and constants for the piecewise-linear curve evaluator.
// ----------------------------------------------------------------------------
package pwl_pkg;

  localparam int DEF_MAX_POINTS = 16;
  localparam int DATA_W         = 32;
  localparam int MODE_W         = 2;
  localparam int SLOT_W         = 4;
  localparam int NPTS_W         = 5;
  localparam int IN_TDATA_W     = 104;  // 102 bits of fields, padded to bytes
  localparam int OUT_TDATA_W    = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 5;
  localparam int DIV_STEPS      = 64;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam int PCT_MAX        = 100;

  // s_tdata field offsets
  localparam int MODE_LSB  = 0;
  localparam int SLOT_LSB  = MODE_LSB + MODE_W;
  localparam int PX_LSB    = SLOT_LSB + SLOT_W;
  localparam int PY_LSB    = PX_LSB + DATA_W;
  localparam int QUERY_LSB = PY_LSB + DATA_W;

  localparam logic [CFG_IDX_W-1:0] REG_NPTS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_FWD   = 2'd1,
    MODE_INV   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch incoming word
    logic wr_point;   // write breakpoint table
    logic res_zero;   // result = 0
    logic idx_clr;
    logic rd;         // read table at idx
    logic idx_inc;
    logic save_prev;  // keep current entry as left end
    logic res_val;    // result = entry value
    logic seg_load;   // register segment deltas
    logic mul;        // product into divider
    logic div_step;
    logic res_quo;    // result = base +/- quotient
    logic out_load;   // clamp and load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  n_zero;
    logic  idx_zero;
    logic  idx_last;
    logic  q_le_key;
    logic  run_pos;
    logic  div_last;
  } sts_t;

endpackage

/* rtl/pwl_dp.sv */
// ----------------------------------------------------------------------------
// pwl_dp
// Datapath: breakpoint tables, segment search registers, 32x32 multiplier,
// radix-2 restoring divider and output register.
// ----------------------------------------------------------------------------
module pwl_dp
  import pwl_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // config
  logic [NPTS_W-1:0] npts;
  logic              clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      npts  <= '0;
      clamp <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_NPTS:  npts  <= cfg_wdata[NPTS_W-1:0];
        REG_CLAMP: clamp <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // latched item
  mode_t              mode;
  logic [SLOT_W-1:0]  slot;
  logic [DATA_W-1:0]  px, py, q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= mode_t'(s_tdata[MODE_LSB +: MODE_W]);
      slot <= s_tdata[SLOT_LSB +: SLOT_W];
      px   <= s_tdata[PX_LSB +: DATA_W];
      py   <= s_tdata[PY_LSB +: DATA_W];
      q    <= s_tdata[QUERY_LSB +: DATA_W];
    end
  end

  // breakpoint tables
  logic [DATA_W-1:0] mem_x [MAX_POINTS];
  logic [DATA_W-1:0] mem_y [MAX_POINTS];
  logic [DATA_W-1:0] rd_x, rd_y;
  logic [IW-1:0]     idx;
  logic              slot_ok;

  assign slot_ok = ({{(32-SLOT_W){1'b0}}, slot} < 32'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (cmd.wr_point && slot_ok) begin
      mem_x[IW'(slot)] <= px;
      mem_y[IW'(slot)] <= py;
    end
    if (cmd.rd) begin
      rd_x <= mem_x[idx];
      rd_y <= mem_y[idx];
    end
  end

  // inverse mode swaps the axes
  logic [DATA_W-1:0] key, val;
  assign key = (mode == MODE_INV) ? rd_y : rd_x;
  assign val = (mode == MODE_INV) ? rd_x : rd_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
  end

  // effective point count
  logic [CW-1:0] n_eff;
  always_comb begin
    if ({{(32-NPTS_W){1'b0}}, npts} > 32'(MAX_POINTS)) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = CW'(npts);
    end
  end

  // left end of current segment
  logic [DATA_W-1:0] pk, pv;
  always_ff @(posedge clk) begin
    if (cmd.save_prev) begin
      pk <= key;
      pv <= val;
    end
  end

  // segment deltas, 33 bit exact
  logic [DATA_W:0] run33, rise33, nx33, rise_neg33;
  assign run33      = {key[DATA_W-1], key} - {pk[DATA_W-1], pk};
  assign rise33     = {val[DATA_W-1], val} - {pv[DATA_W-1], pv};
  assign nx33       = {q[DATA_W-1], q} - {pk[DATA_W-1], pk};
  assign rise_neg33 = -rise33;

  logic [DATA_W-1:0] run, nx, rise_mag, base;
  logic              neg;

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      run      <= run33[DATA_W-1:0];
      nx       <= nx33[DATA_W-1:0];
      rise_mag <= rise33[DATA_W] ? rise_neg33[DATA_W-1:0] : rise33[DATA_W-1:0];
      neg      <= rise33[DATA_W];
      base     <= pv;
    end
  end

  // restoring divider: acc holds dividend, shifts in quotient bits
  logic [2*DATA_W-1:0] acc;
  logic [DATA_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [DATA_W:0]     rem_sh, rem_sub;
  logic                q_bit;

  assign rem_sh  = {rem, acc[2*DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, run};
  assign q_bit   = !rem_sub[DATA_W];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      acc <= 64'(rise_mag) * 64'(nx);
      rem <= '0;
    end else if (cmd.div_step) begin
      acc <= {acc[2*DATA_W-2:0], q_bit};
      rem <= q_bit ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.mul) begin
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + DIV_CNT_W'(1);
    end
  end

  // result register
  logic [DATA_W-1:0] res;
  always_ff @(posedge clk) begin
    if (cmd.res_zero) begin
      res <= '0;
    end else if (cmd.res_val) begin
      res <= val;
    end else if (cmd.res_quo) begin
      // quotient never exceeds the rise, so the low word is exact
      res <= neg ? base - acc[DATA_W-1:0] : base + acc[DATA_W-1:0];
    end
  end

  logic [DATA_W-1:0] res_clamped;
  always_comb begin
    res_clamped = res;
    if (clamp) begin
      if ($signed(res) < 0) begin
        res_clamped = '0;
      end else if ($signed(res) > PCT_MAX) begin
        res_clamped = DATA_W'(PCT_MAX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= res_clamped;
    end
  end

  // status
  assign sts.mode     = mode;
  assign sts.n_zero   = (npts == '0);
  assign sts.idx_zero = (idx == '0);
  assign sts.idx_last = ((CW'(idx) + CW'(1)) == n_eff);
  assign sts.q_le_key = ($signed(q) <= $signed(key));
  assign sts.run_pos  = !run33[DATA_W] && (run33 != '0);
  assign sts.div_last = (dcnt == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

/* rtl/pwl_ctrl.sv */
// ----------------------------------------------------------------------------
// pwl_ctrl
// Controller: sequences decode, segment search, multiply, divide and output.
// ----------------------------------------------------------------------------
module pwl_ctrl
  import pwl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if ((sts.mode inside {MODE_FWD, MODE_INV}) && !sts.n_zero) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_READ: state_next = ST_CHECK;
      ST_CHECK: begin
        if (sts.q_le_key) begin
          if (sts.idx_zero || !sts.run_pos) state_next = ST_DONE;
          else                               state_next = ST_MUL;
        end else if (sts.idx_last) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_next = ST_FIN;
      end
      ST_FIN: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DECODE: begin
        if (sts.mode == MODE_WRITE) begin
          cmd.wr_point = 1'b1;
          cmd.res_zero = 1'b1;
        end else if ((sts.mode inside {MODE_FWD, MODE_INV}) && !sts.n_zero) begin
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.res_zero = 1'b1;
        end
      end
      ST_READ: cmd.rd = 1'b1;
      ST_CHECK: begin
        if (sts.q_le_key) begin
          if (sts.idx_zero || !sts.run_pos) cmd.res_val  = 1'b1;
          else                               cmd.seg_load = 1'b1;
        end else begin
          cmd.save_prev = 1'b1;
          if (sts.idx_last) cmd.res_val = 1'b1;
          else              cmd.idx_inc = 1'b1;
        end
      end
      ST_MUL:  cmd.mul      = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FIN:  cmd.res_quo  = 1'b1;
      ST_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

/* rtl/piecewise_linear_curve_eval_unit.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_curve_eval_unit
// Piecewise-linear curve evaluator over a table of (x, y) breakpoints, with
// forward and inverse lookup and an optional 0..100 clamp.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake           Word
// s_*      in   s_tvalid/s_tready   mode, point_index, point_x, point_y, query
// m_*      out  m_tvalid/m_tready   value
// cfg_*    in   cfg_wen             reg 0 number_of_points, reg 1 clamp_to_percent
//
// Write, unused-mode and empty-table words go from accept straight to the
// result; an evaluation first runs a linear search over the breakpoints and,
// for an interpolated segment, then a multiply, a 64-step restoring divide and
// the result. One word is in flight at a time; the next is accepted as soon as
// the result has moved into the output register, even while m_tready is low.
// Reset clears control and config; the table is undefined until written.
//
module piecewise_linear_curve_eval_unit
  import pwl_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [1:0] mode, [5:2] point_index, [37:6] point_x, [69:38] point_y,
  // [101:70] query, [103:102] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [31:0] value
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  pwl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables, search, multiply/divide, output data
  pwl_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // one word at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a word while one was in flight");

  // never overwrite a result that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // table writes only for write words
  a_write_mode: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_point |-> (sts.mode == MODE_WRITE))
    else $error("table write outside write mode");

  // last divide step is followed by the quotient result
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && sts.div_last |=> cmd.res_quo)
    else $error("divider end not followed by result");

endmodule
